@@ rtl/core/clic_pkg.sv @@
// Shared types, codes and constants of the command line integer calculator.
`default_nettype none
package clic_pkg;

    localparam int DATA_W       = 32;
    localparam int CHAR_W       = 8;
    localparam int PREFIX_CNT_W = 3;
    localparam int PHASE_W      = 8;
    localparam int DIV_CNT_W    = $clog2(DATA_W);
    localparam int PREFIX_LEN_DEF = 5;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [DATA_W-1:0] CH_ZERO  = 32'h0000_0030;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_OP,
        ST_NO_OP,
        ST_DIV_ZERO
    } t_status;

    typedef enum logic [1:0] {
        S_RUN,
        S_CALC,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic parse;
        logic div_init;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_term;
        logic need_div;
        logic div_last;
    } t_dp_sts;

endpackage
`default_nettype wire

@@ rtl/core/clic_dp.sv @@
// Datapath: command parsing, operand registers, arithmetic, divider and output register.
`default_nettype none
module clic_dp #(
    parameter int PREFIX_LEN = clic_pkg::PREFIX_LEN_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire logic signed [clic_pkg::CHAR_W-1:0] i_char_code,
    input  wire clic_pkg::t_dp_cmd              i_cmd,
    output clic_pkg::t_dp_sts                   o_sts,
    output logic signed [clic_pkg::DATA_W-1:0]  o_result_value,
    output logic [1:0]                          o_status_code
);

    localparam int DW = clic_pkg::DATA_W;

    // Parse state.
    logic [clic_pkg::PREFIX_CNT_W-1:0] r_prefix_cnt;
    logic [clic_pkg::PHASE_W-1:0]      r_phase;
    logic [DW-1:0]                     r_first;
    logic [DW-1:0]                     r_second;
    clic_pkg::t_op                     r_op_code;
    logic                              r_op_seen;
    logic                              r_bad_op;

    // Operands captured at the terminator.
    logic [DW-1:0]     r_a;
    logic [DW-1:0]     r_b;
    clic_pkg::t_op     r_op;
    clic_pkg::t_status r_st;

    // Divider.
    logic [DW-1:0]                  r_quo;
    logic [DW-1:0]                  r_rem;
    logic [DW-1:0]                  r_dvs;
    logic                           r_neg;
    logic [clic_pkg::DIV_CNT_W-1:0] r_cnt;

    logic [DW-1:0] r_out_val;
    logic [1:0]    r_out_st;

    logic [DW-1:0]     n_first_fold;
    logic [DW-1:0]     n_second_fold;
    logic [DW-1:0]     char_ext;
    clic_pkg::t_status n_st;
    logic [DW:0]       rem_sh;
    logic [DW:0]       rem_diff;
    logic [DW-1:0]     n_result;
    logic              is_term;

    assign is_term  = (i_char_code == clic_pkg::CH_NUL);
    assign char_ext = {{(DW - clic_pkg::CHAR_W){i_char_code[clic_pkg::CHAR_W-1]}}, i_char_code};
    assign n_first_fold  = (r_first << 3) + (r_first << 1) + char_ext - clic_pkg::CH_ZERO;
    assign n_second_fold = (r_second << 3) + (r_second << 1) + char_ext - clic_pkg::CH_ZERO;

    // Bad operator outranks a missing one, which outranks a zero divisor.
    always_comb begin
        if (r_bad_op) begin
            n_st = clic_pkg::ST_BAD_OP;
        end else if (!r_op_seen) begin
            n_st = clic_pkg::ST_NO_OP;
        end else if (r_op_code == clic_pkg::OP_DIV && r_second == '0) begin
            n_st = clic_pkg::ST_DIV_ZERO;
        end else begin
            n_st = clic_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_cnt <= '0;
            r_phase      <= clic_pkg::PHASE_W'(1);
            r_first      <= '0;
            r_second     <= '0;
            r_op_code    <= clic_pkg::OP_ADD;
            r_op_seen    <= 1'b0;
            r_bad_op     <= 1'b0;
        end else if (i_cmd.parse) begin
            if (is_term) begin
                r_prefix_cnt <= '0;
                r_phase      <= clic_pkg::PHASE_W'(1);
                r_first      <= '0;
                r_second     <= '0;
                r_op_code    <= clic_pkg::OP_ADD;
                r_op_seen    <= 1'b0;
                r_bad_op     <= 1'b0;
            end else if (r_prefix_cnt < clic_pkg::PREFIX_CNT_W'(PREFIX_LEN)) begin
                r_prefix_cnt <= r_prefix_cnt + 1'b1;
            end else if (i_char_code == clic_pkg::CH_SPACE) begin
                r_phase <= r_phase << 1;
            end else if (r_phase[0]) begin
                r_first <= n_first_fold;
            end else if (r_phase[1]) begin
                case (i_char_code)
                    clic_pkg::CH_PLUS: begin
                        r_op_code <= clic_pkg::OP_ADD;
                        r_op_seen <= 1'b1;
                    end
                    clic_pkg::CH_MINUS: begin
                        r_op_code <= clic_pkg::OP_SUB;
                        r_op_seen <= 1'b1;
                    end
                    clic_pkg::CH_STAR: begin
                        r_op_code <= clic_pkg::OP_MUL;
                        r_op_seen <= 1'b1;
                    end
                    clic_pkg::CH_SLASH: begin
                        r_op_code <= clic_pkg::OP_DIV;
                        r_op_seen <= 1'b1;
                    end
                    default: begin
                        r_bad_op <= 1'b1;
                    end
                endcase
            end else if (r_phase[2]) begin
                r_second <= n_second_fold;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.parse && is_term) begin
            r_a  <= r_first;
            r_b  <= r_second;
            r_op <= r_op_code;
            r_st <= n_st;
        end
    end

    // Restoring divider on magnitudes, one quotient bit per cycle.
    assign rem_sh   = {r_rem, r_quo[DW-1]};
    assign rem_diff = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_quo <= r_a[DW-1] ? (DW'(0) - r_a) : r_a;
            r_dvs <= r_b[DW-1] ? (DW'(0) - r_b) : r_b;
            r_rem <= '0;
            r_neg <= r_a[DW-1] ^ r_b[DW-1];
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (!rem_diff[DW]) begin
                r_rem <= rem_diff[DW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (r_st != clic_pkg::ST_OK) begin
            n_result = '0;
        end else begin
            case (r_op)
                clic_pkg::OP_ADD: n_result = r_a + r_b;
                clic_pkg::OP_SUB: n_result = r_a - r_b;
                clic_pkg::OP_MUL: n_result = r_a * r_b;
                clic_pkg::OP_DIV: n_result = r_neg ? (DW'(0) - r_quo) : r_quo;
                default:          n_result = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_val <= n_result;
            r_out_st  <= r_st;
        end
    end

    assign o_sts.is_term  = is_term;
    assign o_sts.need_div = (r_op == clic_pkg::OP_DIV) && (r_st == clic_pkg::ST_OK);
    assign o_sts.div_last = (r_cnt == clic_pkg::DIV_CNT_W'(DW - 1));

    assign o_result_value = r_out_val;
    assign o_status_code  = r_out_st;

endmodule
`default_nettype wire

@@ rtl/core/clic_ctrl.sv @@
// Controller: sequences character intake, result calculation, division and output handshake.
`default_nettype none
module clic_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    output logic                  o_valid,
    input  wire                   i_ready,
    input  wire clic_pkg::t_dp_sts i_sts,
    output clic_pkg::t_dp_cmd     o_cmd
);

    clic_pkg::t_state r_state;
    clic_pkg::t_state n_state;
    logic             r_out_valid;
    logic             out_free;

    assign out_free  = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clic_pkg::S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // Ready is high in the intake state, so a valid request there is always taken.
    always_comb begin
        n_state        = r_state;
        o_ready        = 1'b0;
        o_cmd.parse    = 1'b0;
        o_cmd.div_init = 1'b0;
        o_cmd.div_step = 1'b0;
        o_cmd.load_out = 1'b0;
        case (r_state)
            clic_pkg::S_RUN: begin
                o_ready     = 1'b1;
                o_cmd.parse = i_valid;
                if (i_valid && i_sts.is_term) begin
                    n_state = clic_pkg::S_CALC;
                end
            end
            clic_pkg::S_CALC: begin
                if (i_sts.need_div) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = clic_pkg::S_DIV;
                end else if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = clic_pkg::S_RUN;
                end
            end
            clic_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = clic_pkg::S_FIN;
                end
            end
            clic_pkg::S_FIN: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = clic_pkg::S_RUN;
                end
            end
            default: begin
                n_state = clic_pkg::S_RUN;
            end
        endcase
    end

    // A new result may be loaded in the same cycle the old one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;

endmodule
`default_nettype wire

@@ rtl/core/command_line_integer_calculator.sv @@
// Top level of the command line integer calculator.
// Characters are taken one per cycle; only the zero terminator costs more.
// After the terminator the operands are registered; a division then runs the divider,
// one quotient bit per cycle; each result or status goes to the output register when free.
// The next command's characters are taken again once the result sits in the output register.
// Synchronous active-low reset clears the parse state, controller and output valid.
`default_nettype none
module command_line_integer_calculator #(
    parameter int PREFIX_LEN = clic_pkg::PREFIX_LEN_DEF
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_valid,
    output logic                                     o_ready,
    input  wire logic signed [clic_pkg::CHAR_W-1:0]  i_char_code,
    output logic                                     o_valid,
    input  wire                                      i_ready,
    output logic signed [clic_pkg::DATA_W-1:0]       o_result_value,
    output logic [1:0]                               o_status_code
);

    clic_pkg::t_dp_cmd dp_cmd;
    clic_pkg::t_dp_sts dp_sts;

    clic_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    clic_dp #(
        .PREFIX_LEN (PREFIX_LEN)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_char_code    (i_char_code),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .o_result_value (o_result_value),
        .o_status_code  (o_status_code)
    );

`ifndef SYNTHESIS
    // An error status always carries a zero result.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status_code != clic_pkg::ST_OK) |-> (o_result_value == '0))
        else $error("error status with nonzero result");

    // A terminator stops character intake for at least the next cycle.
    a_term_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_char_code == clic_pkg::CH_NUL) |=> !o_ready)
        else $error("character taken right after terminator");

    // Reset leaves no result pending.
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
`endif

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the command line integer calculator.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STIM_ITEMS   = 1100;
    localparam int TAIL_ITEMS   = 150;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [clic_pkg::DATA_W-1:0] value;
        clic_pkg::t_status           status;
    } t_answer;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_valid = 1'b0;
    logic                               o_ready;
    logic signed [clic_pkg::CHAR_W-1:0] i_char_code = '0;
    logic                               o_valid;
    logic                               i_ready = 1'b0;
    logic signed [clic_pkg::DATA_W-1:0] o_result_value;
    logic [1:0]                         o_status_code;

    command_line_integer_calculator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_char_code    (i_char_code),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_value (o_result_value),
        .o_status_code  (o_status_code)
    );

    logic [clic_pkg::CHAR_W-1:0] char_queue[$];
    logic [clic_pkg::CHAR_W-1:0] cmd_chars[$];
    t_answer                     pending_answers[$];

    // Parser state of the predictor.
    logic [clic_pkg::PREFIX_CNT_W-1:0] skip_count;
    logic [clic_pkg::PHASE_W-1:0]      phase;
    logic [clic_pkg::DATA_W-1:0]       lhs;
    logic [clic_pkg::DATA_W-1:0]       rhs;
    clic_pkg::t_op                     op_code;
    bit                                op_seen;
    bit                                op_bad;

    int  mismatches = 0;
    int  chars_sent = 0;
    int  answers_checked = 0;
    int  status_hits[4] = '{0, 0, 0, 0};
    int  cycles = 0;
    int  gap_left = 0;
    int  calm_left = 0;
    int  stall_left = 0;
    int  ready_calm = 0;
    bit  tail_phase = 1'b0;

    function automatic void clear_parser();
        skip_count = '0;
        phase      = 8'h01;
        lhs        = '0;
        rhs        = '0;
        op_code    = clic_pkg::OP_ADD;
        op_seen    = 1'b0;
        op_bad     = 1'b0;
    endfunction

    // Decimal fold without any digit check; the character is sign-extended.
    function automatic logic [clic_pkg::DATA_W-1:0] fold_char(
        input logic [clic_pkg::DATA_W-1:0] acc,
        input logic [clic_pkg::CHAR_W-1:0] ch
    );
        return acc * 32'd10
               + ({{(clic_pkg::DATA_W-clic_pkg::CHAR_W){ch[clic_pkg::CHAR_W-1]}}, ch}
                  - clic_pkg::CH_ZERO);
    endfunction

    function automatic logic [clic_pkg::DATA_W-1:0] trunc_quotient(
        input logic [clic_pkg::DATA_W-1:0] n,
        input logic [clic_pkg::DATA_W-1:0] d
    );
        logic [clic_pkg::DATA_W-1:0] an;
        logic [clic_pkg::DATA_W-1:0] ad;
        logic [clic_pkg::DATA_W-1:0] q;
        an = n[clic_pkg::DATA_W-1] ? -n : n;
        ad = d[clic_pkg::DATA_W-1] ? -d : d;
        q  = an / ad;
        return (n[clic_pkg::DATA_W-1] ^ d[clic_pkg::DATA_W-1]) ? -q : q;
    endfunction

    function automatic void parse_char(input logic [clic_pkg::CHAR_W-1:0] ch);
        t_answer a;
        if (ch == clic_pkg::CH_NUL) begin
            a.value  = '0;
            a.status = clic_pkg::ST_OK;
            if (op_bad) begin
                a.status = clic_pkg::ST_BAD_OP;
            end else if (!op_seen) begin
                a.status = clic_pkg::ST_NO_OP;
            end else begin
                case (op_code)
                    clic_pkg::OP_ADD: a.value = lhs + rhs;
                    clic_pkg::OP_SUB: a.value = lhs - rhs;
                    clic_pkg::OP_MUL: a.value = lhs * rhs;
                    clic_pkg::OP_DIV: begin
                        if (rhs == '0) a.status = clic_pkg::ST_DIV_ZERO;
                        else a.value = trunc_quotient(lhs, rhs);
                    end
                    default: a.value = '0;
                endcase
            end
            pending_answers.push_back(a);
            clear_parser();
            return;
        end
        if (skip_count < clic_pkg::PREFIX_LEN_DEF) begin
            skip_count = skip_count + 1'b1;
            return;
        end
        if (ch == clic_pkg::CH_SPACE) begin
            phase = phase << 1;
        end else if (phase[0]) begin
            lhs = fold_char(lhs, ch);
        end else if (phase[1]) begin
            case (ch)
                clic_pkg::CH_PLUS:  begin op_code = clic_pkg::OP_ADD; op_seen = 1'b1; end
                clic_pkg::CH_MINUS: begin op_code = clic_pkg::OP_SUB; op_seen = 1'b1; end
                clic_pkg::CH_STAR:  begin op_code = clic_pkg::OP_MUL; op_seen = 1'b1; end
                clic_pkg::CH_SLASH: begin op_code = clic_pkg::OP_DIV; op_seen = 1'b1; end
                default:            op_bad = 1'b1;
            endcase
        end else if (phase[2]) begin
            rhs = fold_char(rhs, ch);
        end
    endfunction

    function automatic logic [clic_pkg::CHAR_W-1:0] any_char();
        return clic_pkg::CHAR_W'($urandom_range(1, 255));
    endfunction

    function automatic logic [clic_pkg::CHAR_W-1:0] junk_char();
        logic [clic_pkg::CHAR_W-1:0] c;
        c = any_char();
        while (c == clic_pkg::CH_SPACE) c = any_char();
        return c;
    endfunction

    function automatic logic [clic_pkg::CHAR_W-1:0] operator_char();
        case ($urandom_range(0, 3))
            0: return clic_pkg::CH_PLUS;
            1: return clic_pkg::CH_MINUS;
            2: return clic_pkg::CH_STAR;
            default: return clic_pkg::CH_SLASH;
        endcase
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) cmd_chars.push_back(s[i]);
    endtask

    task automatic add_digits(input int max_len);
        int n;
        n = $urandom_range(0, max_len);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0) cmd_chars.push_back(junk_char());
            else cmd_chars.push_back(clic_pkg::CHAR_W'(8'h30 + $urandom_range(0, 9)));
        end
    endtask

    task automatic flush_command();
        foreach (cmd_chars[i]) char_queue.push_back(cmd_chars[i]);
        char_queue.push_back(clic_pkg::CH_NUL);
        cmd_chars.delete();
    endtask

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        int kind;
        int n;
        int cut;
        int base;

        // A terminator before any prefix character.
        flush_command();
        // A terminator part way through the prefix.
        push_text("AAAA");
        flush_command();
        // Byte extremes in the prefix, then the wrapping quotient.
        cmd_chars.push_back(8'h80);
        cmd_chars.push_back(8'h7F);
        cmd_chars.push_back(8'hFF);
        cmd_chars.push_back(8'h01);
        cmd_chars.push_back(clic_pkg::CH_SPACE);
        push_text("2147483648 / /");
        flush_command();

        base = char_queue.size();
        while (char_queue.size() < base + STIM_ITEMS) begin
            kind = $urandom_range(0, 19);
            if (kind < 3) begin
                // Pure noise, which often ends inside the prefix.
                n = $urandom_range(0, 24);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0) cmd_chars.push_back(clic_pkg::CH_SPACE);
                    else cmd_chars.push_back(any_char());
                end
            end else begin
                repeat (clic_pkg::PREFIX_LEN_DEF) cmd_chars.push_back(any_char());
                if (kind == 3) begin
                    push_text("2147483648 / /");
                end else begin
                    add_digits(10);
                    cmd_chars.push_back(clic_pkg::CH_SPACE);
                    // An extra space skips the operator phase.
                    if ($urandom_range(0, 9) == 0) cmd_chars.push_back(clic_pkg::CH_SPACE);
                    n = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 3) : 1;
                    repeat (n) begin
                        if ($urandom_range(0, 9) == 0) cmd_chars.push_back(junk_char());
                        else cmd_chars.push_back(operator_char());
                    end
                    cmd_chars.push_back(clic_pkg::CH_SPACE);
                    add_digits(($urandom_range(0, 1) == 0) ? 2 : 10);
                    if ($urandom_range(0, 5) == 0) begin
                        // Later phases, sometimes past the eighth space.
                        n = $urandom_range(1, 9);
                        repeat (n) cmd_chars.push_back(clic_pkg::CH_SPACE);
                        add_digits(4);
                    end
                end
                if (kind == 4 || kind == 5) begin
                    cut = $urandom_range(0, cmd_chars.size());
                    while (cmd_chars.size() > cut) void'(cmd_chars.pop_back());
                end
            end
            flush_command();
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (char_queue.size() != 0 || i_valid || pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_answers.size() != 0) begin
            $display("%0d expected results never arrived", pending_answers.size());
            mismatches += pending_answers.size();
        end
        $display("Sent %0d characters and checked %0d results.", chars_sent, answers_checked);
        $display("Statuses seen: %0d ok, %0d bad operator, %0d no operator, %0d divide by zero.",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3]);
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Request driver: idles in short bursts, with calm stretches and a calm tail.
    always @(posedge i_clk) begin
        bit                          hold;
        logic [clic_pkg::CHAR_W-1:0] nxt;
        hold = i_valid;
        nxt  = i_char_code;
        if (!i_rst_n) begin
            hold      = 1'b0;
            gap_left  = 0;
            calm_left = 0;
            clear_parser();
        end else begin
            if (i_valid && o_ready) begin
                parse_char(i_char_code);
                chars_sent++;
                hold = 1'b0;
            end
            if (!hold) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!tail_phase && calm_left == 0 && $urandom_range(0, 4) == 0) begin
                    gap_left = $urandom_range(0, 6);
                end else if (char_queue.size() > 0) begin
                    nxt  = char_queue.pop_front();
                    hold = 1'b1;
                    if (calm_left > 0) calm_left--;
                    else if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 80);
                end
            end
        end
        i_valid     <= hold;
        i_char_code <= nxt;
        tail_phase  <= (char_queue.size() < TAIL_ITEMS);
    end

    // Result side back-pressure.
    always @(posedge i_clk) begin
        bit rdy;
        rdy = 1'b1;
        if (!i_rst_n) begin
            stall_left = 0;
            ready_calm = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else if (ready_calm > 0) begin
            ready_calm--;
        end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            rdy = 1'b0;
        end else if ($urandom_range(0, 39) == 0) begin
            ready_calm = $urandom_range(20, 80);
        end
        i_ready <= rdy;
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_answer a;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_answers.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: value %0d status %0d",
                             o_result_value, o_status_code);
                mismatches++;
            end else begin
                a = pending_answers.pop_front();
                answers_checked++;
                status_hits[a.status]++;
                if (o_result_value !== a.value || o_status_code !== a.status) begin
                    if (mismatches < 10)
                        $display({"result %0d: expected value %0d status %0d, ",
                                  "got value %0d status %0d"},
                                 answers_checked, $signed(a.value), a.status,
                                 o_result_value, o_status_code);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: FAIL");
            $finish;
        end
    end

endmodule
`default_nettype wire
